FILE: sv/sidi_pkg.sv
// ---------------------------------------------------------------------------
// sidi_pkg: shared types and constants for the decimal text converter
// Word layouts of both channels, BCD chain sizes and character codes.
// ---------------------------------------------------------------------------
package sidi_pkg;

    localparam int VALUE_W    = 32;   // input value width
    localparam int LEN_W      = 4;    // buffer length width
    localparam int CHAR_W     = 8;    // output character width
    localparam int DIGIT_W    = 4;    // one BCD digit
    localparam int NUM_DIGITS = 10;   // enough for 2^32 - 1
    localparam int MAX_CHARS  = 11;   // ten digits and a sign

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CHAR_TERM  = 8'h00;  // terminator

    // input word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [LEN_W-1:0]          buf_len;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_out_word;

endpackage

FILE: sv/sidi_bcd_cell.sv
// ---------------------------------------------------------------------------
// sidi_bcd_cell: one decimal digit of the shift-and-add-3 chain
// Holds a BCD digit; each shift cycle corrects it (add 3 when >= 5), shifts
// in the bit from the lower neighbor and hands its top bit to the next cell.
// ---------------------------------------------------------------------------
module sidi_bcd_cell (
    input  logic                         i_clk,
    input  logic                         i_clear,
    input  logic                         i_shift,
    input  logic                         i_carry,
    output logic                         o_carry,
    output logic [sidi_pkg::DIGIT_W-1:0] o_digit
);

    logic [sidi_pkg::DIGIT_W-1:0] r_digit;
    logic [sidi_pkg::DIGIT_W-1:0] n_digit;
    logic [sidi_pkg::DIGIT_W-1:0] w_adj;

    // add-3 correction before the shift
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[sidi_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    // next digit
    always_comb begin
        n_digit = r_digit;
        if (i_clear) begin
            n_digit = '0;
        end else if (i_shift) begin
            n_digit = {w_adj[sidi_pkg::DIGIT_W-2:0], i_carry};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

FILE: sv/signed_int_to_decimal_ascii_unit.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed 32-bit value to decimal ASCII
// Converts the magnitude through a row of BCD cells, then emits the sign
// and the digits (most significant first; the text is clipped to buf_len - 1
// characters) and a zero terminator marked last.
//
//   channel | ports                       | handshake
//   --------+-----------------------------+----------------------------------
//   input   | i_data (value, buf_len)     | start & !busy accepts a word
//   output  | o_data (character, last)    | o_strobe, one cycle, no stall
//
// Steps: an accept, the shift of every magnitude bit through the BCD cell
// row (one input bit per cycle), sizing of the text, then the emitted
// characters, min(buf_len - 1, text length) of them, and the terminator.
// A zero buf_len word is taken and emits nothing.
// Reset (synchronous, active low) returns the unit to idle.
// The receiver cannot stall; busy stays high until the terminator is out.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  sidi_pkg::t_in_word   i_data,
    output logic                 busy,
    output logic                 o_strobe,
    output sidi_pkg::t_out_word  o_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int CNT_W = $clog2(sidi_pkg::VALUE_W);

    logic [1:0]                        r_state, n_state;
    logic [sidi_pkg::VALUE_W-1:0]      r_mag, n_mag;
    logic                              r_neg, n_neg;
    logic [sidi_pkg::LEN_W-1:0]        r_lenm1, n_lenm1;
    logic [CNT_W-1:0]                  r_cnt, n_cnt;
    logic [3:0]                        r_limit, n_limit;
    logic [3:0]                        r_k, n_k;
    logic                              r_strobe, n_strobe;
    sidi_pkg::t_out_word               r_out, n_out;

    logic                              w_accept;
    logic                              w_clear;
    logic                              w_shift;
    logic [sidi_pkg::NUM_DIGITS:0]     w_carry;
    logic [sidi_pkg::DIGIT_W-1:0]      w_digit [sidi_pkg::NUM_DIGITS];
    logic [3:0]                        w_ndig;
    logic [3:0]                        w_textlen;
    logic [4:0]                        w_pos;
    logic [sidi_pkg::DIGIT_W-1:0]      w_sel;

    assign w_accept = start && !busy;
    assign w_clear  = w_accept;
    assign w_shift  = (r_state == ST_CONV);
    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_data   = r_out;

    // BCD cell row, fed from the top of the magnitude shifter
    assign w_carry[0] = r_mag[sidi_pkg::VALUE_W-1];
    for (genvar g = 0; g < sidi_pkg::NUM_DIGITS; g++) begin : g_cell
        sidi_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_clear (w_clear),
            .i_shift (w_shift),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g])
        );
    end

    // number of significant digits, at least one
    always_comb begin
        w_ndig = 4'd1;
        for (int i = 1; i < sidi_pkg::NUM_DIGITS; i++) begin
            if (w_digit[i] != '0) begin
                w_ndig = 4'(i + 1);
            end
        end
    end
    assign w_textlen = w_ndig + {3'd0, r_neg};

    // digit position of the character at index r_k
    assign w_pos = {1'b0, w_ndig} + {4'd0, r_neg} - 5'd1 - {1'b0, r_k};
    always_comb begin
        w_sel = '0;
        if (w_pos < 5'(sidi_pkg::NUM_DIGITS)) begin
            w_sel = w_digit[w_pos[3:0]];
        end
    end

    // control and output word
    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_lenm1  = r_lenm1;
        n_cnt    = r_cnt;
        n_limit  = r_limit;
        n_k      = r_k;
        n_strobe = 1'b0;
        n_out    = r_out;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_data.buf_len != '0)) begin
                    n_neg   = i_data.value[sidi_pkg::VALUE_W-1];
                    n_mag   = n_neg ? (~i_data.value + 32'd1) : i_data.value;
                    n_lenm1 = i_data.buf_len - 4'd1;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_mag = {r_mag[sidi_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(sidi_pkg::VALUE_W - 1)) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                n_limit = (r_lenm1 < w_textlen) ? r_lenm1 : w_textlen;
                n_k     = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                if (r_k == r_limit) begin
                    n_out.character = sidi_pkg::CHAR_TERM;
                    n_out.last      = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    n_out.last = 1'b0;
                    if (r_neg && (r_k == 4'd0)) begin
                        n_out.character = sidi_pkg::CHAR_MINUS;
                    end else begin
                        n_out.character = sidi_pkg::CHAR_ZERO + {4'd0, w_sel};
                    end
                    n_k = r_k + 4'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_lenm1 <= n_lenm1;
        r_cnt   <= n_cnt;
        r_limit <= n_limit;
        r_k     <= n_k;
        r_out   <= n_out;
    end

`ifndef SYNTHESIS
    // terminator ends the run: no word follows it directly
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_data.last) |=> !o_strobe)
        else $error("word strobed right after terminator");

    // a nonempty request starts a conversion
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_data.buf_len != '0)) |=> (busy && r_state == ST_CONV))
        else $error("accepted request did not start conversion");

    // nothing is emitted while the cell row is shifting
    a_quiet_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !o_strobe)
        else $error("strobe during conversion");

    // emit index never passes the limit
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_k <= r_limit))
        else $error("character index beyond limit");
`endif

endmodule
